FILE: hw/rtl/bdfs_pkg.sv
// Package for the bridge driver fault supervisor.
// Holds the register map, configuration record, shutdown codes and helpers.
// No dependencies; imported by bdfs_regs and the top level.
package bdfs_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

	// Register indexes (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_BOOT_DELAY     = 3'd0,
		REG_POLL_PERIOD    = 3'd1,
		REG_DEBOUNCE_TICKS = 3'd2,
		REG_BAD_LIMIT      = 3'd3,
		REG_EXPECTED_CTRL1 = 3'd4,
		REG_EXPECTED_CTRL4 = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SHUT_NONE   = 2'd0,
		SHUT_LINK   = 2'd1,
		SHUT_DRIVER = 2'd2
	} shut_t;

	typedef struct packed {
		logic [15:0] boot_delay;
		logic [15:0] poll_period;
		logic [15:0] debounce_ticks;
		logic [7:0]  bad_limit;
		logic [7:0]  expected_ctrl1;
		logic [7:0]  expected_ctrl4;
	} cfg_t;

	localparam logic [15:0] BOOT_DELAY_RST     = 16'd2000;
	localparam logic [15:0] POLL_PERIOD_RST    = 16'd1000;
	localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd200;
	localparam logic [7:0]  BAD_LIMIT_RST      = 8'd3;
	localparam logic [7:0]  EXPECTED_CTRL1_RST = 8'h49;
	localparam logic [7:0]  EXPECTED_CTRL4_RST = 8'h0B;

	// Increment that sticks at the all-ones value.
	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

FILE: hw/rtl/bdfs_regs.sv
// Configuration register file of the bridge driver fault supervisor.
// APB-style slave with zero wait states; depends on bdfs_pkg.
module bdfs_regs
	import bdfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_delay     <= BOOT_DELAY_RST;
			cfg_q.poll_period    <= POLL_PERIOD_RST;
			cfg_q.debounce_ticks <= DEBOUNCE_TICKS_RST;
			cfg_q.bad_limit      <= BAD_LIMIT_RST;
			cfg_q.expected_ctrl1 <= EXPECTED_CTRL1_RST;
			cfg_q.expected_ctrl4 <= EXPECTED_CTRL4_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_BOOT_DELAY:     cfg_q.boot_delay     <= pwdata[15:0];
				REG_POLL_PERIOD:    cfg_q.poll_period    <= pwdata[15:0];
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= pwdata[15:0];
				REG_BAD_LIMIT:      cfg_q.bad_limit      <= pwdata[7:0];
				REG_EXPECTED_CTRL1: cfg_q.expected_ctrl1 <= pwdata[7:0];
				REG_EXPECTED_CTRL4: cfg_q.expected_ctrl4 <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BOOT_DELAY:     prdata = {16'd0, cfg_q.boot_delay};
			REG_POLL_PERIOD:    prdata = {16'd0, cfg_q.poll_period};
			REG_DEBOUNCE_TICKS: prdata = {16'd0, cfg_q.debounce_ticks};
			REG_BAD_LIMIT:      prdata = {24'd0, cfg_q.bad_limit};
			REG_EXPECTED_CTRL1: prdata = {24'd0, cfg_q.expected_ctrl1};
			REG_EXPECTED_CTRL4: prdata = {24'd0, cfg_q.expected_ctrl4};
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/bridge_driver_fault_supervisor.sv
// Bridge driver fault supervisor: one tick transaction in, one verdict transaction out.
// A tick transaction is registered in the input register, passes the update logic, and
// its verdict is registered in the result register, where it waits for res_ready.
// Throughput: one tick per cycle while res_ready is high; the single stage of update
// logic between the input register and the result register sets that rate.
// Reset (arst_n low, asynchronous): configuration returns to its defaults, all
// counters and flags clear, the last sampled bytes read back as 0xFF.
module bridge_driver_fault_supervisor
	import bdfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB-style configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Tick channel
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic              fault_pin,
	input  logic [7:0]        fault_byte,
	input  logic [7:0]        diag_byte,
	input  logic [7:0]        ctrl1_byte,
	input  logic [7:0]        ctrl3_byte,
	input  logic [7:0]        ctrl4_byte,
	// Result channel
	output logic              res_valid,
	input  logic              res_ready,
	output logic              healthy,
	output logic              link_ok,
	output logic              config_ok,
	output logic              do_init_writes,
	output logic              sampled,
	output logic [1:0]        shutdown,
	output logic [15:0]       error_count,
	output logic [7:0]        bad_run,
	output logic [7:0]        last_fault,
	output logic [7:0]        last_diag
);

	cfg_t cfg;

	bdfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Input register. A tick transaction lands here and is processed once
	// the result register is free or being emptied.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic       pin_s1;
	logic [7:0] fault_s1, diag_s1, ctrl1_s1, ctrl3_s1, ctrl4_s1;
	logic       advance;

	assign advance    = valid_s1 && (!res_valid || res_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			pin_s1   <= fault_pin;
			fault_s1 <= fault_byte;
			diag_s1  <= diag_byte;
			ctrl1_s1 <= ctrl1_byte;
			ctrl3_s1 <= ctrl3_byte;
			ctrl4_s1 <= ctrl4_byte;
		end
	end

	// ------------------------------------------------------------------
	// Supervisor state.
	// ------------------------------------------------------------------
	logic        ready_q, low_track_q, link_good_q, config_good_q;
	logic [15:0] boot_q, poll_q, low_q, total_q;
	logic [7:0]  streak_q, last_fault_q, last_diag_q;

	logic        ready_n, low_track_n, link_good_n, config_good_n;
	logic [15:0] boot_n, poll_n, low_n, total_n;
	logic [7:0]  streak_n, last_fault_n, last_diag_n;

	logic        healthy_n, init_n, smp_n;
	shut_t       shut_n;

	// ------------------------------------------------------------------
	// Per-tick update. A tick can take the register bytes zero, one or two
	// times: a poll tick that also ends the debounce reads the same bytes
	// twice, so a bad readback then counts twice.
	// ------------------------------------------------------------------
	always_comb begin
		logic [15:0] boot_inc, poll_inc, low_inc;
		logic [7:0]  streak_one;
		logic [8:0]  streak_sum;
		logic [16:0] total_sum;
		logic [1:0]  n_smp;
		logic        bad_rd, cfg_match, poll_hit;

		boot_inc   = sat_inc16(boot_q);
		poll_inc   = sat_inc16(poll_q);
		low_inc    = sat_inc16(low_q);
		bad_rd     = (fault_s1 == BYTE_ALL_ONES) && (diag_s1 == BYTE_ALL_ONES) &&
		             (ctrl1_s1 == BYTE_ALL_ONES) && (ctrl3_s1 == BYTE_ALL_ONES);
		cfg_match  = (ctrl1_s1 == cfg.expected_ctrl1) && (ctrl4_s1 == cfg.expected_ctrl4);
		streak_one = (streak_q == BYTE_ALL_ONES) ? streak_q : streak_q + 8'd1;
		poll_hit   = 1'b0;
		n_smp      = 2'd0;

		ready_n     = ready_q;
		boot_n      = boot_q;
		poll_n      = poll_q;
		low_track_n = low_track_q;
		low_n       = low_q;
		healthy_n   = 1'b1;
		init_n      = 1'b0;
		shut_n      = SHUT_NONE;

		if (!ready_q) begin
			// Boot wait: the pin is ignored until the init tick.
			boot_n = boot_inc;
			if (boot_inc >= cfg.boot_delay) begin
				init_n  = 1'b1;
				n_smp   = 2'd1;
				poll_n  = '0;
				ready_n = 1'b1;
				if (bad_rd) begin
					healthy_n = 1'b0;
					shut_n    = SHUT_LINK;
				end
			end
		end else begin
			poll_hit = (poll_inc >= cfg.poll_period);
			poll_n   = poll_hit ? '0 : poll_inc;
			n_smp    = poll_hit ? 2'd1 : 2'd0;
			if (poll_hit && bad_rd && (streak_one >= cfg.bad_limit)) begin
				// Link fault shutdown skips the pin tracking for this tick.
				healthy_n = 1'b0;
				shut_n    = SHUT_LINK;
			end else begin
				healthy_n = poll_hit ? !bad_rd : link_good_q;
				if (pin_s1) begin
					low_track_n = 1'b0;
					low_n       = '0;
				end else if (!low_track_q) begin
					low_track_n = 1'b1;
					low_n       = '0;
				end else begin
					low_n = low_inc;
					if (low_inc >= cfg.debounce_ticks) begin
						n_smp     = n_smp + 2'd1;
						healthy_n = 1'b0;
						shut_n    = SHUT_DRIVER;
					end
				end
			end
		end

		// Effect of the readbacks on the link bookkeeping.
		smp_n         = (n_smp != 2'd0);
		streak_sum    = {1'b0, streak_q} + {7'd0, n_smp};
		total_sum     = {1'b0, total_q} + {15'd0, n_smp};
		link_good_n   = link_good_q;
		config_good_n = config_good_q;
		streak_n      = streak_q;
		total_n       = total_q;
		last_fault_n  = last_fault_q;
		last_diag_n   = last_diag_q;
		if (n_smp != 2'd0) begin
			last_fault_n = fault_s1;
			last_diag_n  = diag_s1;
			if (bad_rd) begin
				link_good_n   = 1'b0;
				config_good_n = 1'b0;
				streak_n      = streak_sum[8] ? BYTE_ALL_ONES : streak_sum[7:0];
				total_n       = total_sum[16] ? 16'hFFFF : total_sum[15:0];
			end else begin
				link_good_n   = 1'b1;
				config_good_n = cfg_match;
				streak_n      = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q       <= 1'b0;
			boot_q        <= '0;
			poll_q        <= '0;
			low_track_q   <= 1'b0;
			low_q         <= '0;
			link_good_q   <= 1'b0;
			config_good_q <= 1'b0;
			streak_q      <= '0;
			total_q       <= '0;
			last_fault_q  <= BYTE_ALL_ONES;
			last_diag_q   <= BYTE_ALL_ONES;
		end else if (advance) begin
			ready_q       <= ready_n;
			boot_q        <= boot_n;
			poll_q        <= poll_n;
			low_track_q   <= low_track_n;
			low_q         <= low_n;
			link_good_q   <= link_good_n;
			config_good_q <= config_good_n;
			streak_q      <= streak_n;
			total_q       <= total_n;
			last_fault_q  <= last_fault_n;
			last_diag_q   <= last_diag_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It holds a finished verdict while the consumer
	// stalls; the input register keeps accepting as long as this one drains.
	// ------------------------------------------------------------------
	logic        res_valid_q;
	logic        healthy_q, link_ok_q, config_ok_q, init_q, sampled_q;
	shut_t       shutdown_q;
	logic [15:0] error_count_q;
	logic [7:0]  bad_run_q, res_fault_q, res_diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			healthy_q     <= healthy_n;
			link_ok_q     <= link_good_n;
			config_ok_q   <= config_good_n;
			init_q        <= init_n;
			sampled_q     <= smp_n;
			shutdown_q    <= shut_n;
			error_count_q <= total_n;
			bad_run_q     <= streak_n;
			res_fault_q   <= last_fault_n;
			res_diag_q    <= last_diag_n;
		end
	end

	assign res_valid      = res_valid_q;
	assign healthy        = healthy_q;
	assign link_ok        = link_ok_q;
	assign config_ok      = config_ok_q;
	assign do_init_writes = init_q;
	assign sampled        = sampled_q;
	assign shutdown       = shutdown_q;
	assign error_count    = error_count_q;
	assign bad_run        = bad_run_q;
	assign last_fault     = res_fault_q;
	assign last_diag      = res_diag_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Once the boot wait is over the supervisor never goes back to it.
	a_ready_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ready_q))
		else $error("supervisor left the ready state");

	// Any shutdown request comes with an unhealthy verdict.
	a_shut_unhealthy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (shutdown != SHUT_NONE) |-> !healthy)
		else $error("shutdown reported with healthy verdict");

	// A good link means the bad streak has been cleared.
	a_link_streak: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && link_ok |-> (bad_run == 8'd0))
		else $error("bad streak nonzero on a good link");

	// The init writes always come with a readback.
	a_init_sampled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && do_init_writes |-> sampled)
		else $error("init writes without a readback");

endmodule
